@@ rtl/core/swm_pkg.sv @@
// ============================================================================
// swm_pkg - shared types and constants for the 2D sliding window max filter
// Sizes, configuration codes, the front/back queue entry and helper functions.
// ============================================================================
package swm_pkg;

    localparam int MAX_SIZE       = 256;
    localparam int MAX_WINDOW     = 16;
    localparam int VALUE_BITS     = 32;
    localparam int SUM_BITS       = 64;

    localparam int COL_BITS       = $clog2(MAX_SIZE);
    localparam int SIZE_BITS      = COL_BITS + 1;
    localparam int SLOT_BITS      = $clog2(MAX_WINDOW);
    localparam int WIN_BITS       = SLOT_BITS + 1;

    localparam int GROUP_LEN      = 4;
    localparam int GROUPS         = MAX_WINDOW / GROUP_LEN;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 9;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MATRIX_SIZE = 2'd0,
        CFG_WINDOW_SIZE = 2'd1
    } cfg_index_t;

    typedef logic [VALUE_BITS-1:0] value_t;

    // raw register contents, clamped where they are used
    typedef struct packed {
        logic [SIZE_BITS-1:0] matrix_size;
        logic [WIN_BITS-1:0]  window_size;
    } cfg_t;

    // one classified element on its way from the front to the back
    typedef struct packed {
        value_t [GROUPS-1:0]  grp_max;   // row window maxima per group of four
        logic [COL_BITS-1:0]  col;
        logic [SLOT_BITS-1:0] slot;      // row modulo window depth
        logic [WIN_BITS-1:0]  win;       // effective window size
        logic                 store;     // full row window: write line store
        logic                 emit;      // full 2D window: produce a result
        logic                 last;      // last element of the matrix
    } entry_t;

    typedef struct packed {
        logic pop;        // back takes the queue head this cycle
        logic sum_clear;  // running sum is zero
    } back_status_t;

    function automatic value_t max2(input value_t a, input value_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ rtl/core/swm_front.sv @@
// ============================================================================
// swm_front - element intake and classification
// Holds the row window and the position counters, and builds one queue entry
// per accepted element with the group maxima of the row window.
// ============================================================================
module swm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  swm_pkg::cfg_t      cfg,
    input  logic               push,
    input  swm_pkg::value_t    value,
    output swm_pkg::entry_t    entry
);

    swm_pkg::value_t                 win_reg [swm_pkg::MAX_WINDOW];
    swm_pkg::value_t                 win_new [swm_pkg::MAX_WINDOW];
    logic [swm_pkg::COL_BITS-1:0]    col_reg, col_next;
    logic [swm_pkg::COL_BITS-1:0]    row_reg, row_next;
    logic [swm_pkg::SIZE_BITS-1:0]   size_eff;
    logic [swm_pkg::SIZE_BITS-1:0]   last_idx;
    logic [swm_pkg::WIN_BITS-1:0]    win_eff;
    logic                            row_end;
    logic                            mat_end;
    logic                            store;
    logic                            emit;
    swm_pkg::value_t [swm_pkg::GROUPS-1:0] grp_max;

    // clamp registers to their legal range
    always_comb
    begin
        if (cfg.matrix_size == '0)
        begin
            size_eff = swm_pkg::SIZE_BITS'(1);
        end
        else if (cfg.matrix_size > swm_pkg::SIZE_BITS'(swm_pkg::MAX_SIZE))
        begin
            size_eff = swm_pkg::SIZE_BITS'(swm_pkg::MAX_SIZE);
        end
        else
        begin
            size_eff = cfg.matrix_size;
        end

        if (cfg.window_size == '0)
        begin
            win_eff = swm_pkg::WIN_BITS'(1);
        end
        else if (cfg.window_size > swm_pkg::WIN_BITS'(swm_pkg::MAX_WINDOW))
        begin
            win_eff = swm_pkg::WIN_BITS'(swm_pkg::MAX_WINDOW);
        end
        else
        begin
            win_eff = cfg.window_size;
        end
    end

    assign last_idx = size_eff - swm_pkg::SIZE_BITS'(1);
    assign row_end  = ({1'b0, col_reg} >= last_idx);
    assign mat_end  = row_end && ({1'b0, row_reg} >= last_idx);
    assign store    = (({1'b0, col_reg} + swm_pkg::SIZE_BITS'(1))
                       >= swm_pkg::SIZE_BITS'(win_eff));
    assign emit     = store && (({1'b0, row_reg} + swm_pkg::SIZE_BITS'(1))
                       >= swm_pkg::SIZE_BITS'(win_eff));

    // row window after this element is shifted in
    always_comb
    begin
        win_new[0] = value;
        for (int i = 1; i < swm_pkg::MAX_WINDOW; i++)
        begin
            win_new[i] = win_reg[i-1];
        end
    end

    // group maxima over the live part of the window
    always_comb
    begin
        swm_pkg::value_t acc;
        int              idx;
        for (int g = 0; g < swm_pkg::GROUPS; g++)
        begin
            acc = '0;
            for (int i = 0; i < swm_pkg::GROUP_LEN; i++)
            begin
                idx = g * swm_pkg::GROUP_LEN + i;
                if (swm_pkg::WIN_BITS'(idx) < win_eff)
                begin
                    acc = swm_pkg::max2(acc, win_new[idx]);
                end
            end
            grp_max[g] = acc;
        end
    end

    // advance column and row, wrap at row and matrix end
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (mat_end)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (row_end)
        begin
            col_next = '0;
            row_next = row_reg + swm_pkg::COL_BITS'(1);
        end
        else
        begin
            col_next = col_reg + swm_pkg::COL_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < swm_pkg::MAX_WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            for (int i = 0; i < swm_pkg::MAX_WINDOW; i++)
            begin
                win_reg[i] <= win_new[i];
            end
        end
    end

    assign entry.grp_max = grp_max;
    assign entry.col     = col_reg;
    assign entry.slot    = row_reg[swm_pkg::SLOT_BITS-1:0];
    assign entry.win     = win_eff;
    assign entry.store   = store;
    assign entry.emit    = emit;
    assign entry.last    = mat_end;

endmodule

@@ rtl/core/swm_queue.sv @@
// ============================================================================
// swm_queue - short request queue between front and back
// Circular buffer of classified entries; full is registered state only.
// ============================================================================
module swm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  swm_pkg::entry_t    entry_in,
    input  logic               pop,
    output swm_pkg::entry_t    entry_out,
    output logic               not_empty,
    output logic               full
);

    swm_pkg::entry_t                 slot_reg [swm_pkg::QUEUE_DEPTH];
    logic [swm_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [swm_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [swm_pkg::QPTR_BITS:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + swm_pkg::QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + swm_pkg::QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (swm_pkg::QPTR_BITS+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (swm_pkg::QPTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

    assign entry_out = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (swm_pkg::QPTR_BITS+1)'(swm_pkg::QUEUE_DEPTH));

endmodule

@@ rtl/core/swm_back.sv @@
// ============================================================================
// swm_back - line store and window maximum pipeline
// Writes the row maxima into one bank per row slot, reads all banks at the
// column, reduces over the live rows, accumulates the sum, holds the result.
// ============================================================================
module swm_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swm_pkg::entry_t                head,
    input  logic                           head_valid,
    input  logic                           res_stall,
    output swm_pkg::back_status_t          status,
    output logic                           res_valid,
    output logic [swm_pkg::VALUE_BITS-1:0] window_max,
    output logic [swm_pkg::SUM_BITS-1:0]   running_sum,
    output logic                           last_window
);

    logic                                  adv;
    logic                                  pop;
    swm_pkg::value_t                       hmax;
    swm_pkg::value_t                       rd_data [swm_pkg::MAX_WINDOW];

    // stage 1: line store read data
    logic                                  b1_valid_reg;
    swm_pkg::value_t                       b1_hmax_reg;
    logic [swm_pkg::SLOT_BITS-1:0]         b1_slot_reg;
    logic [swm_pkg::WIN_BITS-1:0]          b1_win_reg;
    logic                                  b1_emit_reg;
    logic                                  b1_last_reg;
    swm_pkg::value_t [swm_pkg::GROUPS-1:0] b1_grp;

    // stage 2: group maxima over rows
    logic                                  b2_valid_reg;
    swm_pkg::value_t                       b2_hmax_reg;
    swm_pkg::value_t [swm_pkg::GROUPS-1:0] b2_grp_reg;
    logic                                  b2_emit_reg;
    logic                                  b2_last_reg;
    swm_pkg::value_t                       b2_wmax;

    // stage 3: window maximum
    logic                                  b3_valid_reg;
    swm_pkg::value_t                       b3_wmax_reg;
    logic                                  b3_emit_reg;
    logic                                  b3_last_reg;

    logic [swm_pkg::SUM_BITS-1:0]          sum_reg, sum_next;
    logic [swm_pkg::SUM_BITS-1:0]          sum_inc;
    logic                                  res_valid_reg, res_valid_next;
    swm_pkg::value_t                       res_max_reg;
    logic [swm_pkg::SUM_BITS-1:0]          res_sum_reg;
    logic                                  res_last_reg;

    // whole back pipeline moves when the result register is free
    assign adv = !res_valid_reg || !res_stall;
    assign pop = adv && head_valid;

    always_comb
    begin
        hmax = '0;
        for (int g = 0; g < swm_pkg::GROUPS; g++)
        begin
            hmax = swm_pkg::max2(hmax, head.grp_max[g]);
        end
    end

    // one bank per row slot, all read at the same column
    for (genvar b = 0; b < swm_pkg::MAX_WINDOW; b++)
    begin : g_bank
        swm_pkg::value_t mem [swm_pkg::MAX_SIZE];
        swm_pkg::value_t rd_reg;
        logic            wr_en;

        assign wr_en = pop && head.store && (head.slot == swm_pkg::SLOT_BITS'(b));

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[head.col] <= hmax;
            end
            if (adv)
            begin
                rd_reg <= mem[head.col];
            end
        end

        assign rd_data[b] = rd_reg;
    end

    // keep only the earlier rows of the window; the own row comes from hmax
    always_comb
    begin
        logic [swm_pkg::SLOT_BITS-1:0] row_dist;
        swm_pkg::value_t               masked [swm_pkg::MAX_WINDOW];
        for (int b = 0; b < swm_pkg::MAX_WINDOW; b++)
        begin
            row_dist = b1_slot_reg - swm_pkg::SLOT_BITS'(b);
            if ((row_dist != '0) && ({1'b0, row_dist} < b1_win_reg))
            begin
                masked[b] = rd_data[b];
            end
            else
            begin
                masked[b] = '0;
            end
        end
        for (int g = 0; g < swm_pkg::GROUPS; g++)
        begin
            b1_grp[g] = '0;
            for (int i = 0; i < swm_pkg::GROUP_LEN; i++)
            begin
                b1_grp[g] = swm_pkg::max2(b1_grp[g], masked[g * swm_pkg::GROUP_LEN + i]);
            end
        end
    end

    always_comb
    begin
        b2_wmax = b2_hmax_reg;
        for (int g = 0; g < swm_pkg::GROUPS; g++)
        begin
            b2_wmax = swm_pkg::max2(b2_wmax, b2_grp_reg[g]);
        end
    end

    // accumulate on results, drop the sum at matrix end
    always_comb
    begin
        sum_inc        = sum_reg + swm_pkg::SUM_BITS'(b3_wmax_reg);
        sum_next       = sum_reg;
        res_valid_next = res_valid_reg;
        if (adv)
        begin
            res_valid_next = b3_valid_reg && b3_emit_reg;
            if (b3_valid_reg)
            begin
                if (b3_last_reg)
                begin
                    sum_next = '0;
                end
                else if (b3_emit_reg)
                begin
                    sum_next = sum_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            if (adv)
            begin
                b1_valid_reg <= head_valid;
                b2_valid_reg <= b1_valid_reg;
                b3_valid_reg <= b2_valid_reg;
            end
            res_valid_reg <= res_valid_next;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_hmax_reg  <= hmax;
            b1_slot_reg  <= head.slot;
            b1_win_reg   <= head.win;
            b1_emit_reg  <= head.emit;
            b1_last_reg  <= head.last;

            b2_hmax_reg  <= b1_hmax_reg;
            b2_grp_reg   <= b1_grp;
            b2_emit_reg  <= b1_emit_reg;
            b2_last_reg  <= b1_last_reg;

            b3_wmax_reg  <= b2_wmax;
            b3_emit_reg  <= b2_emit_reg;
            b3_last_reg  <= b2_last_reg;

            res_max_reg  <= b3_wmax_reg;
            res_sum_reg  <= sum_inc;
            res_last_reg <= b3_last_reg;
        end
    end

    assign status.pop       = pop;
    assign status.sum_clear = (sum_reg == '0);

    assign res_valid   = res_valid_reg;
    assign window_max  = res_max_reg;
    assign running_sum = res_sum_reg;
    assign last_window = res_last_reg;

endmodule

@@ rtl/core/sliding_window_max_2d.sv @@
// ============================================================================
// sliding_window_max_2d - streaming 2D maximum filter
// Takes one element per cycle while the queue has room. Throughput is one
// element per cycle while the output is not stalled, set by the back pipeline
// taking one queue entry and one line store write per cycle.
// Reset clears counters, row window and sum, and loads size 256 and window 3;
// the line store is not cleared and needs no clearing pass.
// ============================================================================
//
// Structure:
//   front : row window shift register, column/row counters, classification
//           of each element (row window full, 2D window full, matrix end),
//           and the row window maxima per group of four.
//   queue : four entries; the input stalls only when it is full, so the
//           output stall never reaches the input in the same cycle.
//   back  : sixteen line store banks (one per row slot, 256 columns each).
//           The row maximum is written into the bank of its row slot while
//           all banks are read at the same column; the rows of the window
//           other than the current one are reduced over two stages, then
//           the sum is updated and the result registered.
//
// The back pipeline advances as a whole whenever the result register is
// empty or being taken, so a held result freezes every stage in place,
// including the registered bank read data.
module sliding_window_max_2d (
    input  logic                               clk,
    input  logic                               rst_n,

    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [swm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [swm_pkg::CFG_DATA_BITS-1:0]  cfg_data,

    // element request channel
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [swm_pkg::VALUE_BITS-1:0]     value,

    // result request channel
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [swm_pkg::VALUE_BITS-1:0]     window_max,
    output logic [swm_pkg::SUM_BITS-1:0]       running_sum,
    output logic                               last_window
);

    swm_pkg::cfg_t         cfg_reg, cfg_next;
    logic                  item_accept;
    swm_pkg::entry_t       front_entry;
    swm_pkg::entry_t       head_entry;
    logic                  q_not_empty;
    logic                  q_full;
    swm_pkg::back_status_t back_status;

    // Registers are always writable; an unknown index is ignored.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                swm_pkg::CFG_MATRIX_SIZE:
                begin
                    cfg_next.matrix_size = cfg_data[swm_pkg::SIZE_BITS-1:0];
                end
                swm_pkg::CFG_WINDOW_SIZE:
                begin
                    cfg_next.window_size = cfg_data[swm_pkg::WIN_BITS-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.matrix_size <= swm_pkg::SIZE_BITS'(swm_pkg::MAX_SIZE);
            cfg_reg.window_size <= swm_pkg::WIN_BITS'(3);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Hold the input off only while the queue has no room.
    assign item_stall  = q_full;
    assign item_accept = item_valid && !item_stall;

    swm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .push  (item_accept),
        .value (value),
        .entry (front_entry)
    );

    swm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_accept),
        .entry_in  (front_entry),
        .pop       (back_status.pop),
        .entry_out (head_entry),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    swm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_entry),
        .head_valid  (q_not_empty),
        .res_stall   (res_stall),
        .status      (back_status),
        .res_valid   (res_valid),
        .window_max  (window_max),
        .running_sum (running_sum),
        .last_window (last_window)
    );

    // The last window of a matrix leaves the running sum cleared behind it.
    a_sum_cleared_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && last_window) |-> back_status.sum_clear
    ) else $error("running sum not cleared after last window");

    // The back never takes an entry from an empty queue.
    a_pop_needs_entry: assert property (
        @(posedge clk) disable iff (!rst_n)
        back_status.pop |-> q_not_empty
    ) else $error("queue popped while empty");

    // A full queue keeps the input stalled until the back takes an entry.
    a_full_holds_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (q_full && !back_status.pop) |=> item_stall
    ) else $error("input released while queue still full");

endmodule
